>>> rtl/core/psrf_pkg.sv
// Package for the printable string run finder.
// Holds the shared constants, register codes and beat types; depends on nothing.
`timescale 1ns / 1ps

package psrf_pkg;

   // Fixed field widths
   localparam int ADDR_W  = 48;
   localparam int CNT_W   = 17;
   localparam int MINL_W  = 16;
   localparam int KIND_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int UNIT_W  = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] CNT_MAX = 17'h1FFFF;

   // Printable ranges
   localparam logic [BYTE_W-1:0] ASCII_LO  = 8'h20;
   localparam logic [BYTE_W-1:0] ASCII_HI  = 8'h7E;
   localparam logic [UNIT_W-1:0] WIDE_LO   = 16'h0020;
   localparam logic [UNIT_W-1:0] WIDE_HI   = 16'h007E;
   localparam logic [UNIT_W-1:0] WIDE_EXT  = 16'h00A0;
   localparam logic [UNIT_W-1:0] WIDE_SURR = 16'hD800;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ASCII_ENABLE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNICODE_ENABLE = 2'd2;

   // Register reset values
   localparam logic [MINL_W-1:0] MIN_LENGTH_RST = 16'd4;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [MINL_W-1:0] min_length;
      logic              ascii_enable;
      logic              unicode_enable;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0] string_address;
      logic [CNT_W-1:0]  char_count;
      logic              is_unicode;
      logic [KIND_W-1:0] kind_out;
   } result_type;

   typedef struct packed {
      logic       ascii_valid;
      result_type ascii_res;
      logic       wide_valid;
      result_type wide_res;
   } scan_out_type;

   typedef struct packed {
      result_type res;
      logic       last_of_run;
   } fifo_entry_type;

endpackage

>>> rtl/core/psrf_scan.sv
// Run scanner: tracks the ASCII and UTF-16LE runs over one chunk, one byte a step.
// Depends on psrf_pkg for the config and result types.
`timescale 1ns / 1ps

module psrf_scan
   import psrf_pkg::*;
#(
   parameter int MAX_CHUNK_BYTES = 65536
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [BYTE_W-1:0]   data_byte,
   input  logic [ADDR_W-1:0]   chunk_base,
   input  logic [KIND_W-1:0]   region_kind,
   input  logic                end_of_chunk,
   input  cfg_type             cfg,
   output scan_out_type        scan_out
);

   localparam int OW  = (MAX_CHUNK_BYTES > 1) ? $clog2(MAX_CHUNK_BYTES) : 1;
   localparam int CW  = $clog2(MAX_CHUNK_BYTES + 1);
   localparam int CXW = (CW > CNT_W) ? CW : CNT_W;

   logic [OW-1:0]     off_ff, off_in;
   logic              a_open_ff, a_open_in;
   logic [OW-1:0]     a_start_ff, a_start_in;
   logic              w_open_ff, w_open_in;
   logic [OW-1:0]     w_start_ff, w_start_in;
   logic [BYTE_W-1:0] held_ff, held_in;

   logic              chunk_last;
   logic [CW-1:0]     off_x, off_p1, us_x;
   logic              a_pr, w_pr, odd;
   logic [UNIT_W-1:0] unit;
   logic              a_hit, w_hit;
   logic [OW-1:0]     a_begin, w_begin;
   logic [CW-1:0]     a_end, w_end;
   logic [CW-1:0]     a_len, w_len;
   logic [CXW-1:0]    a_len_x, w_len_x;
   logic [CNT_W-1:0]  a_cnt, w_cnt;

   // Decode the current byte and position
   always_comb begin
      chunk_last = end_of_chunk || (off_ff == OW'(MAX_CHUNK_BYTES - 1));
      off_x      = CW'(off_ff);
      off_p1     = off_x + CW'(1);
      us_x       = {off_x[CW-1:1], 1'b0};
      odd        = off_ff[0];
      a_pr       = (data_byte >= ASCII_LO) && (data_byte <= ASCII_HI);
      unit       = {data_byte, held_ff};
      w_pr       = ((unit >= WIDE_LO) && (unit <= WIDE_HI)) ||
                   ((unit >= WIDE_EXT) && (unit < WIDE_SURR));
   end

   // ASCII run tracking
   always_comb begin
      a_open_in  = a_open_ff;
      a_start_in = a_start_ff;
      a_hit      = 1'b0;
      a_begin    = a_start_ff;
      a_end      = off_x;
      if (!cfg.ascii_enable) begin
         a_open_in = 1'b0;
      end else if (a_pr) begin
         if (!a_open_ff) begin
            a_open_in  = 1'b1;
            a_start_in = off_ff;
            a_begin    = off_ff;
         end
         if (chunk_last) begin
            a_hit     = 1'b1;
            a_end     = off_p1;
            a_open_in = 1'b0;
         end
      end else if (a_open_ff) begin
         a_hit     = 1'b1;
         a_open_in = 1'b0;
      end
      if (chunk_last) begin
         a_open_in = 1'b0;
      end
   end

   // UTF-16LE run tracking; the low byte is held at every even offset
   always_comb begin
      w_open_in  = w_open_ff;
      w_start_in = w_start_ff;
      held_in    = held_ff;
      w_hit      = 1'b0;
      w_begin    = w_start_ff;
      w_end      = off_x;
      if (!odd) begin
         held_in = data_byte;
      end
      if (!cfg.unicode_enable) begin
         w_open_in = 1'b0;
      end else if (!odd) begin
         if (chunk_last && w_open_ff) begin
            w_hit = 1'b1;
         end
      end else if (w_pr) begin
         if (!w_open_ff) begin
            w_open_in  = 1'b1;
            w_start_in = us_x[OW-1:0];
            w_begin    = us_x[OW-1:0];
         end
         if (chunk_last) begin
            w_hit = 1'b1;
            w_end = off_p1;
         end
      end else if (w_open_ff) begin
         w_hit = 1'b1;
         w_end = us_x;
         w_open_in = 1'b0;
      end
      if (chunk_last) begin
         w_open_in = 1'b0;
      end
   end

   // Lengths, saturation and the minimum-length filter
   always_comb begin
      a_len   = a_end - CW'(a_begin);
      w_len   = (w_end - CW'(w_begin)) >> 1;
      a_len_x = CXW'(a_len);
      w_len_x = CXW'(w_len);
      a_cnt   = (a_len_x > CXW'(CNT_MAX)) ? CNT_MAX : a_len_x[CNT_W-1:0];
      w_cnt   = (w_len_x > CXW'(CNT_MAX)) ? CNT_MAX : w_len_x[CNT_W-1:0];

      scan_out.ascii_valid = step && a_hit && (a_len_x >= CXW'(cfg.min_length));
      scan_out.ascii_res.string_address = chunk_base + ADDR_W'(a_begin);
      scan_out.ascii_res.char_count     = a_cnt;
      scan_out.ascii_res.is_unicode     = 1'b0;
      scan_out.ascii_res.kind_out       = region_kind;

      scan_out.wide_valid = step && w_hit && (w_len_x >= CXW'(cfg.min_length));
      scan_out.wide_res.string_address = chunk_base + ADDR_W'(w_begin);
      scan_out.wide_res.char_count     = w_cnt;
      scan_out.wide_res.is_unicode     = 1'b1;
      scan_out.wide_res.kind_out       = region_kind;
   end

   // Advance the offset, wrap at chunk end
   always_comb begin
      off_in = chunk_last ? '0 : OW'(off_x + CW'(1));
   end

   // Scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff     <= '0;
         a_open_ff  <= 1'b0;
         a_start_ff <= '0;
         w_open_ff  <= 1'b0;
         w_start_ff <= '0;
         held_ff    <= '0;
      end else if (step) begin
         off_ff     <= off_in;
         a_open_ff  <= a_open_in;
         a_start_ff <= a_start_in;
         w_open_ff  <= w_open_in;
         w_start_ff <= w_start_in;
         held_ff    <= held_in;
      end
   end

`ifndef SYNTHESIS
   a_off_wrap: assert property (@(posedge clock) disable iff (reset)
      step && chunk_last |=> off_ff == '0)
      else $error("offset did not wrap after chunk end");

   a_ascii_off: assert property (@(posedge clock) disable iff (reset)
      step && !cfg.ascii_enable |=> !a_open_ff)
      else $error("ascii run kept while scan disabled");

   a_wide_even: assert property (@(posedge clock) disable iff (reset)
      w_open_ff |-> w_start_ff[0] == 1'b0)
      else $error("wide run starts at odd offset");
`endif

endmodule

>>> rtl/core/printable_string_run_finder.sv
// Top level of the printable string run finder: input stage, scanner, result queue.
// Depends on psrf_pkg and psrf_scan.
`timescale 1ns / 1ps

// Usage:
//   req_* carries one chunk byte per beat: tdata = data_byte, chunk_base;
//   tuser = region_kind; tlast marks the chunk's final byte.
//   rsp_* carries one found run per beat: tdata = string_address, char_count;
//   tuser = is_unicode, kind_out; tlast marks the final run caused by a byte.
//   csr_* writes min_length (0), ascii_enable (1), unicode_enable (2); write only
//   while no bytes are in flight.
// Path: a run closed by a byte reaches rsp_* through the input register, then
//   the scan into the result queue.
// Throughput: one byte per clock. A byte can close two runs; the four-entry
//   result queue drains one run per clock, and req_tready drops while fewer
//   than two queue slots are free.
// Reset: synchronous; clears the scan state, empties the queue and loads the
//   register defaults (min_length 4, both scans enabled).
// Stall: while rsp_tready is low runs wait in the queue; bytes keep flowing
//   until the queue is nearly full, then req_tready holds low.
module printable_string_run_finder
   import psrf_pkg::*;
#(
   parameter int MAX_CHUNK_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   // Byte channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [55:0]          req_tdata,   // data_byte[7:0], chunk_base[55:8]
   input  logic [KIND_W-1:0]    req_tuser,   // region_kind[1:0]
   input  logic                 req_tlast,
   // Run channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [71:0]          rsp_tdata,   // string_address[47:0], char_count[64:48], zero
   output logic [2:0]           rsp_tuser,   // is_unicode[0], kind_out[2:1]
   output logic                 rsp_tlast,
   // Register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [MINL_W-1:0]    csr_wdata
);

   cfg_type           cfg_ff, cfg_in;

   logic              in_valid_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic [ADDR_W-1:0] in_base_ff;
   logic [KIND_W-1:0] in_kind_ff;
   logic              in_last_ff;

   logic              step;
   logic              req_beat;
   scan_out_type      scan_out;

   fifo_entry_type    fifo_mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FIFO_CNT_W-1:0] push_n;
   logic              pop;
   fifo_entry_type    head;
   fifo_entry_type    ascii_entry, wide_entry;
   logic [FIFO_PTR_W-1:0] wide_slot;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MIN_LENGTH:     cfg_in.min_length     = csr_wdata;
            CSR_ASCII_ENABLE:   cfg_in.ascii_enable   = csr_wdata[0];
            CSR_UNICODE_ENABLE: cfg_in.unicode_enable = csr_wdata[0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length     <= MIN_LENGTH_RST;
         cfg_ff.ascii_enable   <= 1'b1;
         cfg_ff.unicode_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input stage: scan the held byte once two queue slots are free
   assign step       = in_valid_ff && (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || step;
   assign req_beat   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_tdata[7:0];
         in_base_ff <= req_tdata[55:8];
         in_kind_ff <= req_tuser;
         in_last_ff <= req_tlast;
      end
   end

   psrf_scan #(
      .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .chunk_base   (in_base_ff),
      .region_kind  (in_kind_ff),
      .end_of_chunk (in_last_ff),
      .cfg          (cfg_ff),
      .scan_out     (scan_out)
   );

   // Result queue: ASCII run first, tlast on the final run of the byte
   always_comb begin
      push_n    = FIFO_CNT_W'(scan_out.ascii_valid) + FIFO_CNT_W'(scan_out.wide_valid);
      pop       = rsp_tvalid && rsp_tready;
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      cnt_in    = cnt_ff + push_n - FIFO_CNT_W'(pop);

      ascii_entry.res         = scan_out.ascii_res;
      ascii_entry.last_of_run = !scan_out.wide_valid;
      wide_entry.res          = scan_out.wide_res;
      wide_entry.last_of_run  = 1'b1;
      wide_slot               = wr_ptr_ff + FIFO_PTR_W'(scan_out.ascii_valid);
   end

   always_ff @(posedge clock) begin
      if (scan_out.ascii_valid) begin
         fifo_mem[wr_ptr_ff] <= ascii_entry;
      end
      if (scan_out.wide_valid) begin
         fifo_mem[wide_slot] <= wide_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Drive the run channel from the queue head
   assign head       = fifo_mem[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {7'd0, head.res.char_count, head.res.string_address};
   assign rsp_tuser  = {head.res.kind_out, head.res.is_unicode};
   assign rsp_tlast  = head.last_of_run;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("result queue overfilled");

   a_step_room: assert property (@(posedge clock) disable iff (reset)
      step |-> (cnt_ff + push_n) <= FIFO_CNT_W'(FIFO_DEPTH))
      else $error("scan pushed without queue room");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (cnt_ff == '0) && !in_valid_ff)
      else $error("state not cleared by reset");
`endif

endmodule
